>>> rtl/kpc_pkg.sv
// Shared types, constants and helpers for the key press classifier.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package kpc_pkg;

	localparam int KEY_W   = 8;
	localparam int TIME_W  = 32;
	localparam int LIMIT_W = 16;
	localparam int MASK_W  = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MASK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MASK   = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [LIMIT_W-1:0] RST_SHORT_LIMIT = 16'd300;
	localparam logic [LIMIT_W-1:0] RST_LONG_LIMIT  = 16'd1500;
	localparam logic [LIMIT_W-1:0] RST_REPEAT      = 16'd50;
	localparam logic [MASK_W-1:0]  RST_SHORT_MASK  = 5'h1f;
	localparam logic [MASK_W-1:0]  RST_LONG_MASK   = 5'h02;

	// Event kinds.
	localparam logic EVT_SHORT = 1'b0;
	localparam logic EVT_LONG  = 1'b1;

	typedef struct packed {
		logic [LIMIT_W-1:0] short_limit;
		logic [LIMIT_W-1:0] long_limit;
		logic [LIMIT_W-1:0] repeat_ival;
		logic [MASK_W-1:0]  short_mask;
		logic [MASK_W-1:0]  long_mask;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  code;
		logic              kind;
	} evt_t;

	// True when the code is a single key among the low five and its mask bit is set.
	function automatic logic code_enabled(logic [KEY_W-1:0] code, logic [MASK_W-1:0] mask);
		logic [MASK_W-1:0] low;
		logic              one_hot;
		low = code[MASK_W-1:0];
		one_hot = (code[KEY_W-1:MASK_W] == '0) && (low != '0)
			&& ((low & (low - MASK_W'(1))) == '0);
		return one_hot && ((low & mask) != '0);
	endfunction

endpackage

>>> rtl/kpc_cfg_regs.sv
// Configuration register file of the key press classifier.
// Depends on kpc_pkg for the register indexes, widths and reset values.
`timescale 1ns / 1ps

module kpc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [kpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kpc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output kpc_pkg::cfg_t                    cfg
);

	kpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_limit <= kpc_pkg::RST_SHORT_LIMIT;
			cfg_q.long_limit  <= kpc_pkg::RST_LONG_LIMIT;
			cfg_q.repeat_ival <= kpc_pkg::RST_REPEAT;
			cfg_q.short_mask  <= kpc_pkg::RST_SHORT_MASK;
			cfg_q.long_mask   <= kpc_pkg::RST_LONG_MASK;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kpc_pkg::CFG_SHORT_LIMIT: cfg_q.short_limit <= cfg_data;
				kpc_pkg::CFG_LONG_LIMIT:  cfg_q.long_limit  <= cfg_data;
				kpc_pkg::CFG_REPEAT:      cfg_q.repeat_ival <= cfg_data;
				kpc_pkg::CFG_SHORT_MASK:  cfg_q.short_mask  <= cfg_data[kpc_pkg::MASK_W-1:0];
				kpc_pkg::CFG_LONG_MASK:   cfg_q.long_mask   <= cfg_data[kpc_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/kpc_fsm.sv
// Debounce and press classification state machine, one scan per step.
// Depends on kpc_pkg for the configuration and event types.
`timescale 1ns / 1ps

module kpc_fsm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [kpc_pkg::KEY_W-1:0]      key,
	input  logic [kpc_pkg::TIME_W-1:0]     now,
	input  kpc_pkg::cfg_t                  cfg,
	output kpc_pkg::evt_t                  evt
);

	typedef enum logic [2:0] {
		MODE_INIT     = 3'd0,
		MODE_IDLE     = 3'd1,
		MODE_PRESSED  = 3'd2,
		MODE_HELD     = 3'd3,
		MODE_RELEASED = 3'd4,
		MODE_SHORT    = 3'd5,
		MODE_LONG     = 3'd6
	} mode_t;

	mode_t                       mode_q;
	logic                        pending_q;
	logic [kpc_pkg::KEY_W-1:0]   first_q;
	logic [kpc_pkg::TIME_W-1:0]  press_time_q;
	logic [kpc_pkg::TIME_W-1:0]  repeat_time_q;

	logic [kpc_pkg::TIME_W-1:0]  held_for;
	logic [kpc_pkg::TIME_W-1:0]  since_repeat;
	logic                        key_match;
	logic                        past_long;
	logic                        below_short;
	logic                        below_long;
	logic                        repeat_due;

	assign held_for     = now - press_time_q;
	assign since_repeat = now - repeat_time_q;
	assign key_match    = (key == first_q);
	assign past_long    = held_for >= kpc_pkg::TIME_W'(cfg.long_limit);
	assign below_short  = held_for < kpc_pkg::TIME_W'(cfg.short_limit);
	assign below_long   = !past_long;
	assign repeat_due   = since_repeat >= kpc_pkg::TIME_W'(cfg.repeat_ival);

	always_comb begin
		evt.valid = 1'b0;
		evt.code  = first_q;
		evt.kind  = kpc_pkg::EVT_SHORT;
		unique case (mode_q)
			MODE_HELD: begin
				evt.valid = key_match && repeat_due
					&& kpc_pkg::code_enabled(first_q, cfg.short_mask);
			end
			MODE_SHORT: begin
				evt.valid = kpc_pkg::code_enabled(first_q, cfg.short_mask);
			end
			MODE_LONG: begin
				evt.valid = kpc_pkg::code_enabled(first_q, cfg.long_mask);
				evt.kind  = kpc_pkg::EVT_LONG;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_INIT;
			pending_q     <= 1'b0;
			first_q       <= '0;
			press_time_q  <= '0;
			repeat_time_q <= '0;
		end else if (step) begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (key == '0) begin
						pending_q <= 1'b0;
						first_q   <= '0;
					end else if (!pending_q || !key_match) begin
						// A first scan, or a pair that disagrees: the newest scan starts over.
						first_q   <= key;
						pending_q <= 1'b1;
					end else begin
						pending_q    <= 1'b0;
						mode_q       <= MODE_PRESSED;
						press_time_q <= now;
					end
				end
				MODE_PRESSED: begin
					if (key == '0) begin
						mode_q <= MODE_RELEASED;
					end else if (!key_match) begin
						mode_q <= MODE_IDLE;
					end else if (past_long) begin
						mode_q        <= MODE_HELD;
						repeat_time_q <= now;
					end
				end
				MODE_HELD: begin
					if (!key_match) begin
						mode_q <= MODE_IDLE;
					end else if (repeat_due) begin
						repeat_time_q <= now;
					end
				end
				MODE_RELEASED: begin
					if (below_short) begin
						mode_q <= MODE_SHORT;
					end else if (below_long) begin
						mode_q <= MODE_LONG;
					end else begin
						mode_q <= MODE_IDLE;
					end
				end
				default: mode_q <= MODE_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/key_press_classifier_top.sv
// Top level of the key press classifier: input register, state machine, result register.
// Depends on kpc_pkg, kpc_cfg_regs and kpc_fsm.
`timescale 1ns / 1ps

// Usage
// Each input item is one key scan: the raw key bitmap and its millisecond timestamp.
// Scans enter on the in_valid / in_ready channel and are registered first. Once the
// result register is free or being emptied, the state machine classifies the scan
// against its stored state and the configuration, and any event it produces (short
// press, repeat, or long press) lands in the result register, which drives the
// out_valid / out_ready channel. One scan is accepted every cycle while the receiver
// keeps up; most scans produce no event at all, and at most one event follows a scan.
// If the receiver stalls with an event waiting, the registered scan waits too and
// in_ready drops once that register is full; a scan still enters while the waiting
// event is taken in the same cycle.
// The user must write the configuration registers, through cfg_we, cfg_index and
// cfg_data, only while the block is idle; the block itself does not enforce this.
// Reset restores the default limits and masks, empties both registers and puts the
// state machine into its initial mode, which the first scan leaves for idle.
module key_press_classifier_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [kpc_pkg::KEY_W-1:0]        key_bits,
	input  logic [kpc_pkg::TIME_W-1:0]       now_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [kpc_pkg::KEY_W-1:0]        key_code,
	output logic                             event_kind,
	input  logic                             cfg_we,
	input  logic [kpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [kpc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	kpc_pkg::cfg_t cfg;
	kpc_pkg::evt_t evt;

	logic                          valid_s1;
	logic [kpc_pkg::KEY_W-1:0]     key_bits_s1;
	logic [kpc_pkg::TIME_W-1:0]    now_ms_s1;
	logic                          advance_s1;

	logic                          out_valid_q;
	logic [kpc_pkg::KEY_W-1:0]     key_code_q;
	logic                          event_kind_q;

	// The registered scan moves on whenever the result register is free or being emptied.
	assign advance_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	kpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kpc_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance_s1),
		.key    (key_bits_s1),
		.now    (now_ms_s1),
		.cfg    (cfg),
		.evt    (evt)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_bits_s1 <= key_bits;
			now_ms_s1   <= now_ms;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1) begin
			out_valid_q <= evt.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && evt.valid) begin
			key_code_q   <= evt.code;
			event_kind_q <= evt.kind;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_code   = key_code_q;
	assign event_kind = event_kind_q;

endmodule

>>> rtl/kpc_checker.sv
// Port-level assertions for the key press classifier, attached by bind.
// Depends on kpc_pkg and the ports of key_press_classifier_top.
`timescale 1ns / 1ps

module kpc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [kpc_pkg::KEY_W-1:0]      key_code,
	input  logic                           event_kind
);

	// A held result keeps its payload until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_code) && $stable(event_kind))
		else $error("result changed while stalled");

	// Every event names a single key among the low five.
	a_code_one_hot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($onehot(key_code) && (key_code[kpc_pkg::KEY_W-1:kpc_pkg::MASK_W] == '0)))
		else $error("event key code is not a single enabled key");

	// A fresh event follows an accepted scan that passed through the input register and the result register.
	a_event_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("event without a scan two cycles before");

	// While the result register is empty, the input side never stalls.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(out_valid) |-> in_ready)
		else $error("input stalled with an empty result register");

endmodule

bind key_press_classifier_top kpc_checker u_kpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.key_code   (key_code),
	.event_kind (event_kind)
);

>>> tb/tb.sv
// Self-checking testbench for key_press_classifier_top: key scans go in, press events come out.
// Depends on kpc_pkg for widths, register indexes and event kinds, and on key_press_classifier_top.
`timescale 1ns / 1ps

module tb;

	// The run is cut off here if the block hangs; a correct run needs a small fraction of it.
	localparam int unsigned CYCLE_LIMIT = 400000;
	// Cycles to let pass once no event is awaited, enough for a scan still in the pipe.
	localparam int unsigned SETTLE_CYCLES = 4;
	// Scans sent in each phase of random traffic.
	localparam int unsigned PHASE_ITEMS = 170;

	// Modes of the press classifier, kept by the testbench's own copy of the block.
	typedef enum logic [2:0] {
		MODE_INIT, MODE_IDLE, MODE_PRESSED, MODE_HELD, MODE_RELEASED, MODE_SHORT, MODE_LONG
	} scan_mode_t;

	typedef struct packed {
		logic [kpc_pkg::KEY_W-1:0] code;
		logic                      kind;
	} key_event_t;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic [kpc_pkg::KEY_W-1:0]      key_bits;
	logic [kpc_pkg::TIME_W-1:0]     now_ms;
	logic                           out_valid;
	logic                           out_ready;
	logic [kpc_pkg::KEY_W-1:0]      key_code;
	logic                           event_kind;
	logic                           cfg_we;
	logic [kpc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data;

	key_press_classifier_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.key_bits   (key_bits),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_code   (key_code),
		.event_kind (event_kind),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// The testbench's own view of the configuration registers.
	logic [kpc_pkg::LIMIT_W-1:0] lim_short;
	logic [kpc_pkg::LIMIT_W-1:0] lim_long;
	logic [kpc_pkg::LIMIT_W-1:0] ival_repeat;
	logic [kpc_pkg::MASK_W-1:0]  mask_short;
	logic [kpc_pkg::MASK_W-1:0]  mask_long;

	// The testbench's own copy of the classifier state.
	scan_mode_t                  kp_mode;
	logic [1:0]                  scan_cnt;
	logic [kpc_pkg::KEY_W-1:0]   first_key;
	logic [kpc_pkg::KEY_W-1:0]   second_key;
	logic [kpc_pkg::TIME_W-1:0]  press_stamp;
	logic [kpc_pkg::TIME_W-1:0]  repeat_stamp;

	// Events the block owes us, oldest first.
	key_event_t                  awaited_events[$];

	logic [kpc_pkg::TIME_W-1:0]  clock_ms = '0;
	int unsigned                 items_sent = 0;
	int unsigned                 mismatch_count = 0;
	int unsigned                 cycle_count = 0;
	int unsigned                 send_idle_pct = 0;
	int unsigned                 recv_stall_pct = 0;
	int unsigned                 holdoff_request = 0;
	int unsigned                 holdoff_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost event ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Receiver side. A hold-off asked for by a test is counted down here with out_ready
	// held low; otherwise out_ready follows the stall rate of the current phase.
	always @(posedge clk) begin
		if (holdoff_request != 0) begin
			holdoff_left = holdoff_request;
			holdoff_request = 0;
		end
		if (holdoff_left != 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every event taken from the block is compared with the oldest one still awaited.
	always @(posedge clk) begin
		key_event_t ev;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (awaited_events.size() == 0) begin
				$error("event with no scan to cause it: key_code %0h event_kind %0b",
					key_code, event_kind);
				mismatch_count++;
			end else begin
				ev = awaited_events.pop_front();
				if (key_code !== ev.code) begin
					$error("key_code: expected %0h, actual %0h", ev.code, key_code);
					mismatch_count++;
				end
				if (event_kind !== ev.kind) begin
					$error("event_kind: expected %0b, actual %0b", ev.kind, event_kind);
					mismatch_count++;
				end
			end
		end
	end

	// An event is only due when the debounced key is a single one of the low five keys
	// and that key is enabled in the given mask.
	function automatic void queue_key_event(logic kind, logic [kpc_pkg::MASK_W-1:0] mask);
		key_event_t ev;
		for (int b = 0; b < kpc_pkg::MASK_W; b++) begin
			if (first_key == (kpc_pkg::KEY_W'(1) << b) && mask[b]) begin
				ev.code = first_key;
				ev.kind = kind;
				awaited_events.push_back(ev);
			end
		end
	endfunction

	// Advances the classifier copy by one accepted scan and queues the event it causes.
	function automatic void classify_scan(logic [kpc_pkg::KEY_W-1:0] key,
			logic [kpc_pkg::TIME_W-1:0] stamp);
		logic [kpc_pkg::TIME_W-1:0] held_for;
		logic [kpc_pkg::TIME_W-1:0] since_repeat;
		held_for = stamp - press_stamp;
		since_repeat = stamp - repeat_stamp;
		case (kp_mode)
			MODE_IDLE: begin
				if (key == '0) begin
					scan_cnt = '0;
					first_key = '0;
					second_key = '0;
				end else if (scan_cnt == 0) begin
					first_key = key;
					scan_cnt = 2'd1;
				end else begin
					second_key = key;
					if (first_key == second_key) begin
						scan_cnt = '0;
						kp_mode = MODE_PRESSED;
						press_stamp = stamp;
					end else begin
						// A bouncing pair starts over from the newest scan.
						first_key = key;
						scan_cnt = 2'd1;
					end
				end
			end
			MODE_PRESSED: begin
				if (key == '0)
					kp_mode = MODE_RELEASED;
				else if (key != first_key)
					kp_mode = MODE_IDLE;
				else if (held_for >= kpc_pkg::TIME_W'(lim_long)) begin
					kp_mode = MODE_HELD;
					repeat_stamp = stamp;
				end
			end
			MODE_HELD: begin
				if (key == first_key) begin
					if (since_repeat >= kpc_pkg::TIME_W'(ival_repeat)) begin
						queue_key_event(kpc_pkg::EVT_SHORT, mask_short);
						repeat_stamp = stamp;
					end
				end else begin
					kp_mode = MODE_IDLE;
				end
			end
			MODE_RELEASED: begin
				// The hold time is taken at the scan after the release.
				if (held_for < kpc_pkg::TIME_W'(lim_short))
					kp_mode = MODE_SHORT;
				else if (held_for < kpc_pkg::TIME_W'(lim_long))
					kp_mode = MODE_LONG;
				else
					kp_mode = MODE_IDLE;
			end
			MODE_SHORT: begin
				queue_key_event(kpc_pkg::EVT_SHORT, mask_short);
				kp_mode = MODE_IDLE;
			end
			MODE_LONG: begin
				queue_key_event(kpc_pkg::EVT_LONG, mask_long);
				kp_mode = MODE_IDLE;
			end
			default: kp_mode = MODE_IDLE;
		endcase
	endfunction

	// Offers one scan, taken delta_ms after the previous one, and waits until it is accepted.
	// in_valid is left high on return so that a following item can go out back to back;
	// the next call drives it anew and settle() lowers it.
	task automatic send_scan(input logic [kpc_pkg::KEY_W-1:0] key,
			input logic [kpc_pkg::TIME_W-1:0] delta_ms);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		clock_ms += delta_ms;
		in_valid <= 1'b1;
		key_bits <= key;
		now_ms <= clock_ms;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		items_sent++;
		classify_scan(key, clock_ms);
	endtask

	// Stops offering scans and waits until the block has delivered every awaited event,
	// then waits out SETTLE_CYCLES for a scan that causes none.
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; cfg_we stays high so that writes can follow back to back.
	task automatic put_reg(input logic [kpc_pkg::CFG_IDX_W-1:0] idx,
			input logic [kpc_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			kpc_pkg::CFG_SHORT_LIMIT: lim_short = data;
			kpc_pkg::CFG_LONG_LIMIT:  lim_long = data;
			kpc_pkg::CFG_REPEAT:      ival_repeat = data;
			kpc_pkg::CFG_SHORT_MASK:  mask_short = data[kpc_pkg::MASK_W-1:0];
			kpc_pkg::CFG_LONG_MASK:   mask_long = data[kpc_pkg::MASK_W-1:0];
			default: ;
		endcase
	endtask

	// Writes all five registers, with junk in the unused upper bits of the masks, and one
	// write to an index past the last register, which the block must ignore.
	task automatic write_config(input logic [kpc_pkg::LIMIT_W-1:0] s_lim,
			input logic [kpc_pkg::LIMIT_W-1:0] l_lim,
			input logic [kpc_pkg::LIMIT_W-1:0] rep, input logic [kpc_pkg::MASK_W-1:0] s_mask,
			input logic [kpc_pkg::MASK_W-1:0] l_mask);
		logic [kpc_pkg::CFG_DATA_W-1:0] s_data;
		logic [kpc_pkg::CFG_DATA_W-1:0] l_data;
		s_data = kpc_pkg::CFG_DATA_W'($urandom());
		s_data[kpc_pkg::MASK_W-1:0] = s_mask;
		l_data = kpc_pkg::CFG_DATA_W'($urandom());
		l_data[kpc_pkg::MASK_W-1:0] = l_mask;
		put_reg(kpc_pkg::CFG_SHORT_LIMIT, s_lim);
		put_reg(kpc_pkg::CFG_LONG_LIMIT, l_lim);
		put_reg(kpc_pkg::CFG_REPEAT, rep);
		put_reg(kpc_pkg::CFG_SHORT_MASK, s_data);
		put_reg(kpc_pkg::CFG_LONG_MASK, l_data);
		put_reg(kpc_pkg::CFG_IDX_W'(kpc_pkg::CFG_LONG_MASK + 1 + $urandom_range(2)),
			kpc_pkg::CFG_DATA_W'($urandom()));
		cfg_we <= 1'b0;
	endtask

	// A limit that is now and then one of the extremes, otherwise in a useful range.
	function automatic logic [kpc_pkg::LIMIT_W-1:0] pick_limit(int unsigned typical);
		case ($urandom_range(9))
			0: return kpc_pkg::LIMIT_W'(1);
			1: return '1;
			default: return kpc_pkg::LIMIT_W'($urandom_range(typical, 1));
		endcase
	endfunction

	// Default registers: the first scan leaves the initial mode, then a short press, a
	// press after a bouncing pair released as a long press, a key chord that is never
	// reported, a release that comes too late, and a press aborted by another key.
	task automatic test_short_and_long_press();
		send_scan(8'h00, '0);
		send_scan(8'h01, 10);
		send_scan(8'h01, 10);
		send_scan(8'h00, 100);
		send_scan(8'h00, 10);
		send_scan(8'h00, 10);
		send_scan(8'h80, 10);
		send_scan(8'h02, 10);
		send_scan(8'h02, 10);
		send_scan(8'h00, 800);
		send_scan(8'h00, 10);
		send_scan(8'h00, 10);
		send_scan(8'hff, 10);
		send_scan(8'hff, 10);
		send_scan(8'h00, 20);
		send_scan(8'h00, 10);
		send_scan(8'h00, 10);
		send_scan(8'h02, 10);
		send_scan(8'h02, 10);
		send_scan(8'h00, 2000);
		send_scan(8'h00, 10);
		send_scan(8'h04, 10);
		send_scan(8'h04, 10);
		send_scan(8'h01, 10);
		settle();
	endtask

	// Auto-repeat across the wrap of the millisecond counter: the press lands on the
	// largest timestamp and the hold time is measured across zero.
	task automatic test_auto_repeat_wrap();
		clock_ms = 32'hffff_fffd;
		send_scan(8'h10, 1);
		send_scan(8'h10, 1);
		send_scan(8'h10, 1600);
		send_scan(8'h10, 50);
		send_scan(8'h10, 10);
		send_scan(8'h08, 1);
		settle();
	endtask

	// Every register at its extremes, including a short limit above the long limit and
	// masks that let nothing out.
	task automatic test_config_extremes();
		write_config('1, kpc_pkg::LIMIT_W'(1), kpc_pkg::LIMIT_W'(1), '1, '1);
		send_scan(8'h08, 3);
		send_scan(8'h08, 1);
		send_scan(8'h00, 0);
		send_scan(8'h00, 5);
		send_scan(8'h00, 1);
		send_scan(8'h04, 1);
		send_scan(8'h04, 1);
		send_scan(8'h04, 1);
		send_scan(8'h04, 1);
		send_scan(8'h04, 0);
		send_scan(8'h04, 1);
		send_scan(8'h00, 1);
		settle();
		write_config(kpc_pkg::LIMIT_W'(1), '1, '1, '0, '1);
		send_scan(8'h01, 1);
		send_scan(8'h01, 1);
		send_scan(8'h00, 1);
		send_scan(8'h00, 30000);
		send_scan(8'h00, 1);
		send_scan(8'h02, 1);
		send_scan(8'h02, 1);
		send_scan(8'h02, 32'h0000_ffff);
		send_scan(8'h02, 32'h0000_ffff);
		send_scan(8'h00, 1);
		settle();
		write_config(kpc_pkg::LIMIT_W'(1), '1, '1, '0, '0);
		send_scan(8'h02, 1);
		send_scan(8'h02, 1);
		send_scan(8'h00, 1);
		send_scan(8'h00, 100);
		send_scan(8'h00, 1);
		settle();
	endtask

	// A repeat event on every scan while the receiver holds off for a long stretch, so
	// the result register fills and the block has to stall its input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_config(kpc_pkg::RST_SHORT_LIMIT, kpc_pkg::LIMIT_W'(1), kpc_pkg::LIMIT_W'(1), '1,
			kpc_pkg::RST_LONG_MASK);
		send_scan(8'h01, 1);
		send_scan(8'h01, 1);
		send_scan(8'h01, 1);
		holdoff_request = 80;
		repeat (40) send_scan(8'h01, 1);
		send_scan(8'h00, 1);
		settle();
	endtask

	// One press gesture with random key and timing: an optional bounce, the debounce
	// pair, some held scans with the odd stray key, then the release and two more scans
	// so that a short or long event can come out.
	task automatic random_gesture();
		logic [kpc_pkg::KEY_W-1:0] key;
		int unsigned               span;
		int unsigned               holds;
		case ($urandom_range(9))
			7: key = kpc_pkg::KEY_W'(1) << $urandom_range(kpc_pkg::KEY_W-1, kpc_pkg::MASK_W);
			8, 9: key = kpc_pkg::KEY_W'($urandom_range(255, 1));
			default: key = kpc_pkg::KEY_W'(1) << $urandom_range(kpc_pkg::MASK_W-1);
		endcase
		case ($urandom_range(3))
			0: span = lim_short / 2 + 1;
			1: span = lim_long / 3 + 1;
			2: span = ival_repeat + ival_repeat / 2 + 1;
			default: span = 4;
		endcase
		holds = $urandom_range(6);
		if ($urandom_range(4) == 0)
			send_scan(kpc_pkg::KEY_W'($urandom_range(255, 1)), $urandom_range(3));
		send_scan(key, $urandom_range(5));
		send_scan(key, $urandom_range(5));
		repeat (holds) begin
			if ($urandom_range(19) == 0)
				send_scan(key ^ kpc_pkg::KEY_W'($urandom_range(255, 1)), $urandom_range(span));
			else
				send_scan(key, $urandom_range(span));
		end
		send_scan('0, $urandom_range(span));
		send_scan('0, $urandom_range(span));
		send_scan('0, $urandom_range(3));
	endtask

	// Four phases of random traffic, one per idling pattern, each under fresh registers.
	// Most items are press gestures; the rest are raw noise scans, some with a timestamp
	// jump anywhere in the 32-bit range.
	task automatic test_random_traffic();
		int unsigned idle_pct[4];
		int unsigned stall_pct[4];
		int unsigned first_item;
		idle_pct = '{0, 68, 0, 36};
		stall_pct = '{0, 0, 68, 36};
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			send_idle_pct = idle_pct[ph];
			recv_stall_pct = stall_pct[ph];
			write_config(pick_limit(400), pick_limit(2000), pick_limit(200),
				kpc_pkg::MASK_W'($urandom_range(31, 1)),
				kpc_pkg::MASK_W'($urandom_range(31, 1)));
			first_item = items_sent;
			while (items_sent - first_item < PHASE_ITEMS) begin
				if ($urandom_range(4) != 0)
					random_gesture();
				else
					repeat ($urandom_range(4, 1))
						send_scan(kpc_pkg::KEY_W'($urandom()),
							($urandom_range(19) == 0) ? $urandom() : $urandom_range(40));
			end
		end
		settle();
	endtask

	initial begin
		// Inputs are known from the first instant, while reset is held.
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		key_bits <= '0;
		now_ms <= '0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;

		lim_short = kpc_pkg::RST_SHORT_LIMIT;
		lim_long = kpc_pkg::RST_LONG_LIMIT;
		ival_repeat = kpc_pkg::RST_REPEAT;
		mask_short = kpc_pkg::RST_SHORT_MASK;
		mask_long = kpc_pkg::RST_LONG_MASK;
		kp_mode = MODE_INIT;
		scan_cnt = '0;
		first_key = '0;
		second_key = '0;
		press_stamp = '0;
		repeat_stamp = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_short_and_long_press();
		test_auto_repeat_wrap();
		test_config_extremes();
		test_backpressure();
		test_random_traffic();

		// settle() has already waited out every awaited event and the pipeline.
		if (mismatch_count == 0 && awaited_events.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
